// ----- design/tkct_pkg.sv -----
// Shared types and constants for the typed key cache table.
package tkct_pkg;

  localparam int unsigned KeyTypeBits = 8;
  localparam int unsigned CookieBits = 64;
  localparam int unsigned PortPayloadBits = 32;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_MISS = 2'd2,
    ST_FULL = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

endpackage

// ----- design/tkct_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module tkct_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/typed_key_cache_table.sv -----
// Top level of the typed key cache table: request sequencer, key compare and valid bits.
// Each request walks the entries one per cycle through a single key comparator fed by
// the entry RAM. The result is registered at the output once the scan ends at the first
// matching entry, where the scan stops, or at the last entry.
// One request is in flight at a time; the next one is accepted only after the result
// reaches the output register. Reset is asynchronous and active low; it clears all
// valid bits at once, so no clearing pass is needed and the table starts empty.
module typed_key_cache_table
  import tkct_pkg::*;
#(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 mode_i,
  input  logic [KeyTypeBits-1:0]     key_type_i,
  input  logic [CookieBits-1:0]      cookie_key_i,
  input  logic [PortPayloadBits-1:0] payload_in_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic [PortPayloadBits-1:0] payload_out_o
);

  localparam int unsigned IdxW = $clog2(ENTRIES);
  localparam int unsigned StoreBits =
      (PAYLOAD_BITS < PortPayloadBits) ? PAYLOAD_BITS : PortPayloadBits;
  localparam int unsigned RamW = KeyTypeBits + CookieBits + StoreBits;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

  state_e state_q, state_d;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic free_found_q, free_found_d;
  logic [IdxW-1:0] free_idx_q, free_idx_d;

  mode_e mode_q;
  logic [KeyTypeBits-1:0] type_q;
  logic [CookieBits-1:0] cookie_q;
  logic [StoreBits-1:0] payload_q;

  status_e res_status_q, res_status_d;
  logic [StoreBits-1:0] res_payload_q, res_payload_d;

  logic out_valid_q, out_valid_d;
  logic [1:0] out_status_q;
  logic [PortPayloadBits-1:0] out_payload_q;

  logic accept;
  logic [IdxW-1:0] raddr;
  logic [RamW-1:0] rdata;
  logic we;
  logic [IdxW-1:0] waddr;
  logic hit;
  logic last;
  logic free_now;
  logic [IdxW-1:0] free_sel;
  logic out_load;

  assign accept = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  assign hit = valid_q[idx_q]
      && (rdata[RamW-1 -: KeyTypeBits] == type_q)
      && (rdata[StoreBits +: CookieBits] == cookie_q);
  assign last = (idx_q == LastIdx);
  assign free_now = free_found_q || !valid_q[idx_q];
  assign free_sel = free_found_q ? free_idx_q : idx_q;
  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    raddr = '0;
    if (state_q == S_SCAN && !last) begin
      raddr = idx_q + IdxW'(1);
    end
  end

  always_comb begin
    state_d = state_q;
    valid_d = valid_q;
    idx_d = idx_q;
    free_found_d = free_found_q;
    free_idx_d = free_idx_q;
    res_status_d = res_status_q;
    res_payload_d = res_payload_q;
    we = 1'b0;
    waddr = free_sel;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SCAN;
          idx_d = '0;
          free_found_d = 1'b0;
        end
      end
      S_SCAN: begin
        if (!free_found_q && !valid_q[idx_q]) begin
          free_found_d = 1'b1;
          free_idx_d = idx_q;
        end
        idx_d = idx_q + IdxW'(1);
        if (hit || last) begin
          state_d = S_DONE;
          res_payload_d = '0;
          res_status_d = ST_MISS;
          unique case (mode_q)
            MODE_INSERT: begin
              if (hit) begin
                res_status_d = ST_DUP;
              end else if (free_now) begin
                res_status_d = ST_OK;
                we = 1'b1;
                valid_d[free_sel] = 1'b1;
              end else begin
                res_status_d = ST_FULL;
              end
            end
            MODE_LOOKUP, MODE_REMOVE: begin
              if (hit) begin
                res_status_d = ST_OK;
                res_payload_d = rdata[StoreBits-1:0];
                if (mode_q == MODE_REMOVE) begin
                  valid_d[idx_q] = 1'b0;
                end
              end
            end
            default: begin
              res_status_d = ST_MISS;
            end
          endcase
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    free_found_q <= free_found_d;
    free_idx_q <= free_idx_d;
    res_status_q <= res_status_d;
    res_payload_q <= res_payload_d;
    if (accept) begin
      mode_q <= mode_e'(mode_i);
      type_q <= key_type_i;
      cookie_q <= cookie_key_i;
      payload_q <= payload_in_i[StoreBits-1:0];
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_payload_q <= PortPayloadBits'(res_payload_q);
    end
  end

  tkct_ram #(
    .Width(RamW),
    .Depth(ENTRIES)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i({type_q, cookie_q, payload_q}),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign out_valid_o = out_valid_q;
  assign status_o = out_status_q;
  assign payload_out_o = out_payload_q;

endmodule
